>>> rtl/core/e2q_pkg.sv
// e2q_pkg: shared types, widths and the CORDIC arctangent table for euler_to_quaternion
// depends on nothing; used by every module of the block
`default_nettype none

package e2q_pkg;

	// field widths fixed by the interface
	localparam int FIELD_W = 16;
	localparam int RAW_W   = 32;

	// CORDIC datapath widths: x and y in Q30 with headroom, z in units where 2^32 = pi
	localparam int XY_W = 34;
	localparam int Z_W  = 35;

	// CORDIC gain compensation, 0.60725293500888 in Q30
	localparam logic signed [XY_W-1:0] K_Q30 = 34'sd652032874;

	// products of two Q30 factors
	localparam int PROD_W = 2 * XY_W;

	typedef struct packed {
		logic signed [FIELD_W-1:0] roll_angle;
		logic signed [FIELD_W-1:0] pitch_angle;
		logic signed [FIELD_W-1:0] yaw_angle;
	} angles_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] q_w;
		logic signed [FIELD_W-1:0] q_x;
		logic signed [FIELD_W-1:0] q_y;
		logic signed [FIELD_W-1:0] q_z;
	} quat_t;

	// cosine and sine of one half angle, Q30
	typedef struct packed {
		logic signed [XY_W-1:0] c;
		logic signed [XY_W-1:0] s;
	} cs_t;

	// doubled arctangent of 2^-i, units where 2^32 = pi; zero past the table
	function automatic logic signed [Z_W-1:0] atan_step(input int i);
		logic signed [Z_W-1:0] a;
		case (i)
			0:  a = 35'sd536870912;
			1:  a = 35'sd316933406;
			2:  a = 35'sd167458907;
			3:  a = 35'sd85004756;
			4:  a = 35'sd42667331;
			5:  a = 35'sd21354465;
			6:  a = 35'sd10679838;
			7:  a = 35'sd5340245;
			8:  a = 35'sd2670163;
			9:  a = 35'sd1335087;
			10: a = 35'sd667544;
			11: a = 35'sd333772;
			12: a = 35'sd166886;
			13: a = 35'sd83443;
			14: a = 35'sd41721;
			15: a = 35'sd20860;
			16: a = 35'sd10430;
			17: a = 35'sd5215;
			18: a = 35'sd2607;
			19: a = 35'sd1303;
			20: a = 35'sd651;
			21: a = 35'sd325;
			22: a = 35'sd162;
			23: a = 35'sd81;
			24: a = 35'sd40;
			25: a = 35'sd20;
			26: a = 35'sd10;
			27: a = 35'sd5;
			28: a = 35'sd2;
			29: a = 35'sd1;
			default: a = '0;
		endcase
		return a <<< 1;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/euler_to_quaternion.sv
// euler_to_quaternion: roll/pitch/yaw binary angles to unit attitude quaternion (ZYX)
// depends on e2q_pkg, e2q_cordic, e2q_prod
//
//  channel  dir  handshake                     word
//  angles   in   angles_valid / angles_ready   e2q_pkg::angles_t
//  quat     out  quat_valid / quat_ready       e2q_pkg::quat_t
//
// the pipeline has one register stage per CORDIC iteration, then two multiply stages
// and a round/clamp stage that is also the output register.
// one word enters per cycle while the output is not stalled; throughput is one word per cycle.
// a stalled output word freezes the whole pipeline, angles_ready follows it.
// reset clears only the valid bits.
`default_nettype none

module euler_to_quaternion #(
	parameter int ANGLE_BITS    = 16,
	parameter int FRAC_BITS     = 14,
	parameter int CORDIC_STAGES = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   angles_valid,
	output logic                  angles_ready,
	input  wire e2q_pkg::angles_t angles,
	output logic                  quat_valid,
	input  wire                   quat_ready,
	output e2q_pkg::quat_t        quat
);

	localparam int DEPTH = CORDIC_STAGES + 3;

	logic         en;
	logic [DEPTH-1:0] valid_s;
	e2q_pkg::cs_t roll_cs, pitch_cs, yaw_cs;

	// pipeline advances whenever the output register is free or being taken
	assign en           = !valid_s[DEPTH-1] || quat_ready;
	assign angles_ready = en;
	assign quat_valid   = valid_s[DEPTH-1];

	// valid bits move with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[DEPTH-2:0], angles_valid};
		end
	end

	// half-angle cosine and sine of each axis
	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .en(en), .angle(angles.roll_angle), .cs(roll_cs)
	);
	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .en(en), .angle(angles.pitch_angle), .cs(pitch_cs)
	);
	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .en(en), .angle(angles.yaw_angle), .cs(yaw_cs)
	);

	// quaternion products
	e2q_prod #(.FRAC_BITS(FRAC_BITS)) u_prod (
		.clk(clk), .en(en), .roll(roll_cs), .pitch(pitch_cs), .yaw(yaw_cs), .quat(quat)
	);

endmodule

`default_nettype wire

>>> rtl/core/e2q_cordic.sv
// e2q_cordic: pipelined rotation-mode CORDIC, one register stage per iteration
// depends on e2q_pkg
`default_nettype none

module e2q_cordic #(
	parameter int ANGLE_BITS = 16,
	parameter int STAGES     = 16
) (
	input  wire                              clk,
	input  wire                              en,
	input  wire logic [e2q_pkg::FIELD_W-1:0] angle,
	output e2q_pkg::cs_t                     cs
);

	localparam int XY_W = e2q_pkg::XY_W;
	localparam int Z_W  = e2q_pkg::Z_W;

	logic [e2q_pkg::RAW_W-1:0]  raw;
	logic signed [ANGLE_BITS-1:0] ang;

	logic signed [XY_W-1:0] x_s [0:STAGES];
	logic signed [XY_W-1:0] y_s [0:STAGES];
	logic signed [Z_W-1:0]  z_s [0:STAGES-1];

	// half angle: sign extend the low angle bits and scale to 2^32 = pi
	assign raw    = {{(e2q_pkg::RAW_W - e2q_pkg::FIELD_W){1'b0}}, angle};
	assign ang    = raw[ANGLE_BITS-1:0];
	assign z_s[0] = Z_W'(ang) <<< (32 - ANGLE_BITS);
	assign x_s[0] = e2q_pkg::K_Q30;
	assign y_s[0] = '0;

	// one micro-rotation per stage
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [Z_W-1:0] ATAN = e2q_pkg::atan_step(i);
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][Z_W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
				end
			end
		end

		// the last stage needs no angle residue
		if (i < STAGES - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (en) begin
					if (!z_s[i][Z_W-1]) z_s[i+1] <= z_s[i] - ATAN;
					else z_s[i+1] <= z_s[i] + ATAN;
				end
			end
		end
	end

	assign cs.c = x_s[STAGES];
	assign cs.s = y_s[STAGES];

endmodule

`default_nettype wire

>>> rtl/core/e2q_prod.sv
// e2q_prod: three-stage product tree forming the ZYX quaternion from half-angle cos/sin
// depends on e2q_pkg
`default_nettype none

module e2q_prod #(
	parameter int FRAC_BITS = 14
) (
	input  wire               clk,
	input  wire               en,
	input  wire e2q_pkg::cs_t roll,
	input  wire e2q_pkg::cs_t pitch,
	input  wire e2q_pkg::cs_t yaw,
	output e2q_pkg::quat_t    quat
);

	localparam int XY_W  = e2q_pkg::XY_W;
	localparam int P_W   = e2q_pkg::PROD_W;
	localparam int SUM_W = P_W + 1;
	localparam int SH    = 60 - FRAC_BITS;
	localparam int OUT_W = e2q_pkg::FIELD_W;

	// round a Q60 product to Q30
	function automatic logic signed [XY_W-1:0] rnd30(input logic signed [P_W-1:0] p);
		logic signed [P_W-1:0] r;
		r = (p + (P_W'(1) <<< 29)) >>> 30;
		return r[XY_W-1:0];
	endfunction

	// round to FRAC_BITS and clamp to the output range
	function automatic logic signed [OUT_W-1:0] finish(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(32767);
		lo = -SUM_W'(32768);
		r  = (v + (SUM_W'(1) <<< (SH - 1))) >>> SH;
		if (r > hi) return hi[OUT_W-1:0];
		else if (r < lo) return lo[OUT_W-1:0];
		else return r[OUT_W-1:0];
	endfunction

	logic signed [P_W-1:0]  ccp, ssp, scp, csp;
	logic signed [XY_W-1:0] ccp_s1, ssp_s1, scp_s1, csp_s1, cy_s1, sy_s1;
	logic signed [P_W-1:0]  w1_s2, w2_s2, x1_s2, x2_s2, y1_s2, y2_s2, z1_s2, z2_s2;

	// roll by pitch products
	assign ccp = roll.c * pitch.c;
	assign ssp = roll.s * pitch.s;
	assign scp = roll.s * pitch.c;
	assign csp = roll.c * pitch.s;

	always_ff @(posedge clk) begin
		if (en) begin
			ccp_s1 <= rnd30(ccp);
			ssp_s1 <= rnd30(ssp);
			scp_s1 <= rnd30(scp);
			csp_s1 <= rnd30(csp);
			cy_s1  <= yaw.c;
			sy_s1  <= yaw.s;
		end
	end

	// times the yaw factor
	always_ff @(posedge clk) begin
		if (en) begin
			w1_s2 <= ccp_s1 * cy_s1;
			w2_s2 <= ssp_s1 * sy_s1;
			x1_s2 <= scp_s1 * cy_s1;
			x2_s2 <= csp_s1 * sy_s1;
			y1_s2 <= csp_s1 * cy_s1;
			y2_s2 <= scp_s1 * sy_s1;
			z1_s2 <= ccp_s1 * sy_s1;
			z2_s2 <= ssp_s1 * cy_s1;
		end
	end

	// combine, round and clamp into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			quat.q_w <= finish(SUM_W'(w1_s2) + SUM_W'(w2_s2));
			quat.q_x <= finish(SUM_W'(x1_s2) - SUM_W'(x2_s2));
			quat.q_y <= finish(SUM_W'(y1_s2) + SUM_W'(y2_s2));
			quat.q_z <= finish(SUM_W'(z1_s2) - SUM_W'(z2_s2));
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/e2q_checker.sv
// e2q_checker: port-level checks for euler_to_quaternion, bound to the top level
// depends on e2q_pkg
`default_nettype none

module e2q_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   angles_valid,
	input wire                   angles_ready,
	input wire e2q_pkg::angles_t angles,
	input wire                   quat_valid,
	input wire                   quat_ready,
	input wire e2q_pkg::quat_t   quat
);

	// no word shows during reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !quat_valid)
		else $error("quat_valid high in reset");

	// input side is ready exactly when the output register can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		angles_ready == (!quat_valid || quat_ready))
		else $error("angles_ready does not follow output stall");

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && !quat_ready |=> quat_valid)
		else $error("quat_valid dropped while stalled");

	// a stalled word keeps its value
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && !quat_ready |=> $stable(quat))
		else $error("quat changed while stalled");

	// an offered input word is fully defined
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid |-> !$isunknown(angles))
		else $error("angles unknown while offered");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
	.clk(clk), .arst_n(arst_n),
	.angles_valid(angles_valid), .angles_ready(angles_ready), .angles(angles),
	.quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat)
);

`default_nettype wire
